// ===== rtl/scalar_kalman_velocity_filter_unit_assert.svh =====
// Assertion macros of the checker of the scalar Kalman velocity filter.
`ifndef SCALAR_KALMAN_VELOCITY_FILTER_UNIT_ASSERT_SVH
`define SCALAR_KALMAN_VELOCITY_FILTER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SKVF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SKVF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// The consequent must hold later than the antecedent.
`define SKVF_ASSERT_LATER(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

// ===== rtl/skvf_pkg.sv =====
// Shared types and constants of the scalar Kalman velocity filter.
package skvf_pkg;

  // Width of every fixed-point value on the data path.
  localparam int unsigned DATA_W = 32;

  // Default number of fraction bits.
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Saturation limits of a 32-bit signed value.
  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_GAIN_A       = 3'd0,
    CFG_GAIN_B       = 3'd1,
    CFG_GAIN_C       = 3'd2,
    CFG_PROC_NOISE   = 3'd3,
    CFG_MEAS_NOISE   = 3'd4,
    CFG_INIT_VAR     = 3'd5
  } cfg_idx_e;

  // Control of the shared arithmetic unit for one cycle.
  typedef struct packed {
    logic mul_en;   // capture a new product
    logic add_sub;  // adder subtracts its second operand
  } alu_ctrl_t;

endpackage

// ===== rtl/scalar_kalman_velocity_filter_unit.sv =====
// Top level of the scalar Kalman velocity filter: configuration, sequencer and stream ports.
//
// One measurement enters on the slave stream (s_axis_*) and one filtered estimate leaves on
// the master stream (m_axis_*) for it. Both carry a signed fixed-point value with FRAC_BITS
// fraction bits in tdata. Filter coefficients and noise terms are written through the
// cfg_* port; the user must write them only while the block is idle, which the block
// does not enforce. Indexes above five are ignored. After an input transaction,
// s_axis_tready stays low for seventeen steps of the shared multiplier and adder plus
// the wait on the bit-serial gain divider. The estimate becomes valid in the same cycle
// as s_axis_tready rises again. s_axis_tready is high only while no item is in work,
// so one item is processed at a time.
// The estimate is held in an output register; the next measurement can be taken while it
// waits. If the receiver still stalls when the following estimate is done, the sequencer
// holds in its last step until the output register is free.
// Reset sets every coefficient and noise term to 1.0, clears the estimates and the error
// variance, and marks the first step as pending: the first item loads the error variance
// from the initial-variance register before predicting.
module scalar_kalman_velocity_filter_unit #(
  parameter int unsigned FRAC_BITS = skvf_pkg::FRAC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration write port
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  // Measurement stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // [31:0] measurement
  // Estimate stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [31:0]  m_axis_tdata    // [31:0] estimate
);

  localparam int unsigned W = skvf_pkg::DATA_W;
  localparam logic signed [W-1:0] ONE = W'(64'd1 << FRAC_BITS);

  typedef enum logic [18:0] {
    ST_IDLE  = 19'd1,
    ST_DIFF  = 19'd2,
    ST_XA    = 19'd4,
    ST_XP    = 19'd8,
    ST_PA    = 19'd16,
    ST_PAA   = 19'd32,
    ST_PP    = 19'd64,
    ST_CP    = 19'd128,
    ST_CPW   = 19'd256,
    ST_CPC   = 19'd512,
    ST_KV    = 19'd1024,
    ST_NUM   = 19'd2048,
    ST_INNOV = 19'd4096,
    ST_DIVW  = 19'd8192,
    ST_GI    = 19'd16384,
    ST_XN    = 19'd32768,
    ST_TT    = 19'd65536,
    ST_TP    = 19'd131072,
    ST_PN    = 19'd262144
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic signed [W-1:0] gain_a_q, gain_b_q, gain_c_q;
  logic [W-2:0]        proc_noise_q, meas_noise_q, init_var_q;

  // Filter state and intermediate values
  logic                started_q;
  logic signed [W-1:0] xcur_q, xprv_q, pvar_q;
  logic signed [W-1:0] meas_q, diff_q, t0_q, xprd_q, pprd_q, kvar_q, innov_q, gain_q, xnew_q;

  // Output register
  logic                out_valid_q;
  logic [W-1:0]        out_data_q;

  // Shared unit hookup
  skvf_pkg::alu_ctrl_t alu_ctrl;
  logic signed [W-1:0] mul_a, mul_b, add_a, add_b, mul_res, add_res;
  logic                div_start, div_done;
  logic signed [W-1:0] div_quot;

  logic in_fire;
  logic commit;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign commit        = (state_q == ST_PN) && (!out_valid_q || m_axis_tready);
  assign div_start     = (state_q == ST_INNOV);

  skvf_alu #(
    .FRAC_BITS (FRAC_BITS)
  ) u_alu (
    .clk_i     (clk_i),
    .ctrl_i    (alu_ctrl),
    .mul_a_i   (mul_a),
    .mul_b_i   (mul_b),
    .add_a_i   (add_a),
    .add_b_i   (add_b),
    .mul_res_o (mul_res),
    .add_res_o (add_res)
  );

  skvf_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (t0_q),
    .den_i   (kvar_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Operand selection and next state for each step.
  always_comb begin
    alu_ctrl = '0;
    mul_a    = '0;
    mul_b    = '0;
    add_a    = '0;
    add_b    = '0;
    state_d  = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_DIFF;
        end
      end
      ST_DIFF: begin
        add_a            = xcur_q;
        add_b            = xprv_q;
        alu_ctrl.add_sub = 1'b1;
        mul_a            = gain_a_q;
        mul_b            = xcur_q;
        alu_ctrl.mul_en  = 1'b1;
        state_d          = ST_XA;
      end
      ST_XA: begin
        mul_a           = gain_b_q;
        mul_b           = diff_q;
        alu_ctrl.mul_en = 1'b1;
        state_d         = ST_XP;
      end
      ST_XP: begin
        add_a           = t0_q;
        add_b           = mul_res;
        mul_a           = gain_a_q;
        mul_b           = pvar_q;
        alu_ctrl.mul_en = 1'b1;
        state_d         = ST_PA;
      end
      ST_PA: begin
        state_d = ST_PAA;
      end
      ST_PAA: begin
        mul_a           = t0_q;
        mul_b           = gain_a_q;
        alu_ctrl.mul_en = 1'b1;
        state_d         = ST_PP;
      end
      ST_PP: begin
        add_a   = mul_res;
        add_b   = {1'b0, proc_noise_q};
        state_d = ST_CP;
      end
      ST_CP: begin
        mul_a           = gain_c_q;
        mul_b           = pprd_q;
        alu_ctrl.mul_en = 1'b1;
        state_d         = ST_CPW;
      end
      ST_CPW: begin
        state_d = ST_CPC;
      end
      ST_CPC: begin
        mul_a           = t0_q;
        mul_b           = gain_c_q;
        alu_ctrl.mul_en = 1'b1;
        state_d         = ST_KV;
      end
      ST_KV: begin
        add_a           = mul_res;
        add_b           = {1'b0, meas_noise_q};
        mul_a           = pprd_q;
        mul_b           = gain_c_q;
        alu_ctrl.mul_en = 1'b1;
        state_d         = ST_NUM;
      end
      ST_NUM: begin
        mul_a           = gain_c_q;
        mul_b           = xprd_q;
        alu_ctrl.mul_en = 1'b1;
        state_d         = ST_INNOV;
      end
      ST_INNOV: begin
        add_a            = meas_q;
        add_b            = mul_res;
        alu_ctrl.add_sub = 1'b1;
        state_d          = ST_DIVW;
      end
      ST_DIVW: begin
        if (div_done) begin
          state_d = ST_GI;
        end
      end
      ST_GI: begin
        mul_a           = gain_q;
        mul_b           = innov_q;
        alu_ctrl.mul_en = 1'b1;
        state_d         = ST_XN;
      end
      ST_XN: begin
        add_a           = xprd_q;
        add_b           = mul_res;
        mul_a           = gain_q;
        mul_b           = gain_c_q;
        alu_ctrl.mul_en = 1'b1;
        state_d         = ST_TT;
      end
      ST_TT: begin
        add_a            = ONE;
        add_b            = mul_res;
        alu_ctrl.add_sub = 1'b1;
        state_d          = ST_TP;
      end
      ST_TP: begin
        mul_a           = t0_q;
        mul_b           = pprd_q;
        alu_ctrl.mul_en = 1'b1;
        state_d         = ST_PN;
      end
      ST_PN: begin
        if (commit) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Sequencer state, filter state, configuration and output handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      started_q    <= 1'b0;
      xcur_q       <= '0;
      xprv_q       <= '0;
      pvar_q       <= '0;
      gain_a_q     <= ONE;
      gain_b_q     <= ONE;
      gain_c_q     <= ONE;
      proc_noise_q <= ONE[W-2:0];
      meas_noise_q <= ONE[W-2:0];
      init_var_q   <= ONE[W-2:0];
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      // Register writes; unknown indexes fall through.
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          skvf_pkg::CFG_GAIN_A:     gain_a_q     <= cfg_data_i;
          skvf_pkg::CFG_GAIN_B:     gain_b_q     <= cfg_data_i;
          skvf_pkg::CFG_GAIN_C:     gain_c_q     <= cfg_data_i;
          skvf_pkg::CFG_PROC_NOISE: proc_noise_q <= cfg_data_i[W-2:0];
          skvf_pkg::CFG_MEAS_NOISE: meas_noise_q <= cfg_data_i[W-2:0];
          skvf_pkg::CFG_INIT_VAR:   init_var_q   <= cfg_data_i[W-2:0];
          default: ;
        endcase
      end

      // The first item loads the error variance before predicting.
      if (in_fire && !started_q) begin
        pvar_q    <= {1'b0, init_var_q};
        started_q <= 1'b1;
      end

      // Commit the step and hand the estimate to the output register.
      if (commit) begin
        xprv_q      <= xcur_q;
        xcur_q      <= xnew_q;
        pvar_q      <= mul_res;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Intermediate values written by the steps.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      meas_q <= s_axis_tdata;
    end
    if (commit) begin
      out_data_q <= xnew_q;
    end
    unique case (state_q)
      ST_DIFF:  diff_q  <= add_res;
      ST_XA:    t0_q    <= mul_res;
      ST_XP:    xprd_q  <= add_res;
      ST_PA:    t0_q    <= mul_res;
      ST_PP:    pprd_q  <= add_res;
      ST_CPW:   t0_q    <= mul_res;
      ST_KV:    kvar_q  <= add_res;
      ST_NUM:   t0_q    <= mul_res;
      ST_INNOV: innov_q <= add_res;
      ST_DIVW: begin
        if (div_done) begin
          gain_q <= div_quot;
        end
      end
      ST_XN:    xnew_q  <= add_res;
      ST_TT:    t0_q    <= add_res;
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== rtl/skvf_alu.sv =====
// Shared arithmetic unit: registered 32x32 multiplier with fixed-point scaling and a
// saturating adder.
module skvf_alu #(
  parameter int unsigned FRAC_BITS = skvf_pkg::FRAC_BITS_DEF
) (
  input  logic                                    clk_i,
  input  skvf_pkg::alu_ctrl_t                     ctrl_i,
  input  logic signed [skvf_pkg::DATA_W-1:0]      mul_a_i,
  input  logic signed [skvf_pkg::DATA_W-1:0]      mul_b_i,
  input  logic signed [skvf_pkg::DATA_W-1:0]      add_a_i,
  input  logic signed [skvf_pkg::DATA_W-1:0]      add_b_i,
  output logic signed [skvf_pkg::DATA_W-1:0]      mul_res_o,
  output logic signed [skvf_pkg::DATA_W-1:0]      add_res_o
);

  localparam int unsigned PW = 2 * skvf_pkg::DATA_W;

  logic signed [PW-1:0]                 prod_q;
  logic signed [PW-1:0]                 prod_sh;
  logic signed [skvf_pkg::DATA_W:0]     sum;

  // Full product, held until the next multiply is issued.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= mul_a_i * mul_b_i;
    end
  end

  // Scale down rounding toward minus infinity, then saturate to 32 bits.
  always_comb begin
    prod_sh = prod_q >>> FRAC_BITS;
    if ((&prod_sh[PW-1:skvf_pkg::DATA_W-1]) || !(|prod_sh[PW-1:skvf_pkg::DATA_W-1])) begin
      mul_res_o = prod_sh[skvf_pkg::DATA_W-1:0];
    end else if (prod_sh[PW-1]) begin
      mul_res_o = skvf_pkg::S32_MIN;
    end else begin
      mul_res_o = skvf_pkg::S32_MAX;
    end
  end

  // Saturating add or subtract on one guard bit.
  always_comb begin
    if (ctrl_i.add_sub) begin
      sum = {add_a_i[skvf_pkg::DATA_W-1], add_a_i} - {add_b_i[skvf_pkg::DATA_W-1], add_b_i};
    end else begin
      sum = {add_a_i[skvf_pkg::DATA_W-1], add_a_i} + {add_b_i[skvf_pkg::DATA_W-1], add_b_i};
    end
    if (sum[skvf_pkg::DATA_W] == sum[skvf_pkg::DATA_W-1]) begin
      add_res_o = sum[skvf_pkg::DATA_W-1:0];
    end else if (sum[skvf_pkg::DATA_W]) begin
      add_res_o = skvf_pkg::S32_MIN;
    end else begin
      add_res_o = skvf_pkg::S32_MAX;
    end
  end

endmodule

// ===== rtl/skvf_div.sv =====
// Radix-2 restoring divider for the Kalman gain: (num << FRAC_BITS) / den, truncated and
// saturated, zero for a zero divisor.
module skvf_div #(
  parameter int unsigned FRAC_BITS = skvf_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [skvf_pkg::DATA_W-1:0]   num_i,
  input  logic signed [skvf_pkg::DATA_W-1:0]   den_i,
  output logic                                 done_o,
  output logic signed [skvf_pkg::DATA_W-1:0]   quot_o
);

  localparam int unsigned W  = skvf_pkg::DATA_W;
  localparam int unsigned DW = W + FRAC_BITS;
  localparam int unsigned CW = $clog2(DW + 1);

  logic                 busy_q;
  logic                 done_q;
  logic [CW-1:0]        cnt_q;
  logic [W-1:0]         rem_q;
  logic [DW-1:0]        quo_q;
  logic [W-1:0]         dm_q;
  logic                 neg_q;
  logic                 zero_q;
  logic signed [W-1:0]  res_q;

  logic [W-1:0]         num_mag;
  logic [W-1:0]         den_mag;
  logic [W:0]           rem_sh;
  logic                 ge;
  logic signed [W-1:0]  res_d;

  // Operand magnitudes; the most negative value maps to 2^31 unsigned.
  assign num_mag = num_i[W-1] ? (~num_i + 1'b1) : num_i;
  assign den_mag = den_i[W-1] ? (~den_i + 1'b1) : den_i;

  // One quotient bit per cycle.
  assign rem_sh = {rem_q, quo_q[DW-1]};
  assign ge     = (rem_sh >= {1'b0, dm_q});

  // Sign and saturation of the finished magnitude quotient.
  always_comb begin
    if (zero_q) begin
      res_d = '0;
    end else if (neg_q) begin
      if ((|quo_q[DW-1:W]) || (quo_q[W-1] && (|quo_q[W-2:0]))) begin
        res_d = skvf_pkg::S32_MIN;
      end else begin
        res_d = ~quo_q[W-1:0] + 1'b1;
      end
    end else if (|quo_q[DW-1:W-1]) begin
      res_d = skvf_pkg::S32_MAX;
    end else begin
      res_d = quo_q[W-1:0];
    end
  end

  // Control of the iteration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // Data path of the iteration; the partial remainder stays below the divisor.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q  <= {num_mag, {FRAC_BITS{1'b0}}};
      rem_q  <= '0;
      dm_q   <= den_mag;
      neg_q  <= num_i[W-1] ^ den_i[W-1];
      zero_q <= (den_i == '0);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        res_q <= res_d;
      end else begin
        rem_q <= ge ? W'(rem_sh - {1'b0, dm_q}) : rem_sh[W-1:0];
        quo_q <= {quo_q[DW-2:0], ge};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = res_q;

endmodule

// ===== rtl/skvf_checker.sv =====
// Port-level checker of the scalar Kalman velocity filter and its bind.
`include "scalar_kalman_velocity_filter_unit_assert.svh"

module skvf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // A stalled estimate keeps its value.
  `SKVF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "estimate dropped or changed under stall")

  // Once a measurement is taken, the block is busy in the following cycles.
  `SKVF_ASSERT_NEXT(a_busy_next, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready right after an accepted measurement")

  `SKVF_ASSERT_LATER(a_busy_later, s_axis_tvalid && s_axis_tready, !s_axis_tready, "ready two cycles after an accepted measurement")

  // A new estimate appears only at the end of a busy period.
  `SKVF_ASSERT_SAME(a_out_from_work, $rose(m_axis_tvalid), $past(!s_axis_tready), "estimate appeared without work in progress")

endmodule

bind scalar_kalman_velocity_filter_unit skvf_checker u_skvf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== verif/scalar_kalman_velocity_filter_unit_tb.sv =====
// Self-checking testbench of the scalar Kalman velocity filter: directed table, random phases.
module scalar_kalman_velocity_filter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import skvf_pkg::*;

  localparam int unsigned FRAC = FRAC_BITS_DEF;
  localparam longint ONE = longint'(1) << FRAC;
  localparam longint SAT_HI = longint'(S32_MAX);
  localparam longint SAT_LO = longint'(S32_MIN);
  localparam int CLK_PERIOD = 10;
  localparam int RESET_CYCLES = 7;
  // Busy time of one item plus some margin.
  localparam int BUSY_CYCLES = 20 + 32 + FRAC + 12;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int PHASES = 16;
  localparam int ITEMS_PER_PHASE = 106;
  localparam int STEADY_PHASE = 3;
  localparam int PRESSURE_PHASE = 7;
  localparam int PRESSURE_CYCLES = 400;
  localparam int MAX_REPORTS = 10;

  // Register indexes that the block ignores.
  localparam logic [2:0] CFG_SPARE_LO = 3'd6;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;
  // Register field of a measurement row; it carries no meaning there.
  localparam logic [2:0] NO_REG = 3'd0;
  localparam logic ROW_CFG = 1'b1;
  localparam logic ROW_MEAS = 1'b0;
  localparam logic KNOWN = 1'b1;
  localparam logic PRED = 1'b0;

  typedef struct packed {
    logic        is_cfg;
    logic [2:0]  reg_idx;
    logic [31:0] value;
    logic        known;
    logic [31:0] estimate;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 44;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    // First step loads the largest initial variance; other registers keep their reset values.
    '{ROW_CFG,  CFG_INIT_VAR,   32'h7fff_ffff, PRED,  32'h0},
    '{ROW_MEAS, NO_REG,         32'h0003_0000, PRED,  32'h0},
    '{ROW_MEAS, NO_REG,         32'h7fff_ffff, PRED,  32'h0},
    '{ROW_MEAS, NO_REG,         32'h8000_0000, PRED,  32'h0},
    '{ROW_MEAS, NO_REG,         32'hffff_ffff, PRED,  32'h0},
    // All coefficients and noise zero: zero innovation variance, zero gain, zero estimate.
    '{ROW_CFG,  CFG_GAIN_A,     32'h0,         PRED,  32'h0},
    '{ROW_CFG,  CFG_GAIN_B,     32'h0,         PRED,  32'h0},
    '{ROW_CFG,  CFG_GAIN_C,     32'h0,         PRED,  32'h0},
    '{ROW_CFG,  CFG_MEAS_NOISE, 32'h0,         PRED,  32'h0},
    '{ROW_CFG,  CFG_PROC_NOISE, 32'h0,         PRED,  32'h0},
    '{ROW_MEAS, NO_REG,         32'h7fff_ffff, KNOWN, 32'h0},
    '{ROW_MEAS, NO_REG,         32'h8000_0000, KNOWN, 32'h0},
    // Writes to indexes above five change nothing.
    '{ROW_CFG,  CFG_SPARE_LO,   32'hffff_ffff, PRED,  32'h0},
    '{ROW_CFG,  CFG_SPARE_HI,   32'h1234_5678, PRED,  32'h0},
    '{ROW_MEAS, NO_REG,         32'h0001_0000, KNOWN, 32'h0},
    // Largest coefficients A and C, most negative B, largest noise: saturation all along the data path.
    '{ROW_CFG,  CFG_GAIN_A,     32'h7fff_ffff, PRED,  32'h0},
    '{ROW_CFG,  CFG_GAIN_B,     32'h8000_0000, PRED,  32'h0},
    '{ROW_CFG,  CFG_GAIN_C,     32'h7fff_ffff, PRED,  32'h0},
    '{ROW_CFG,  CFG_PROC_NOISE, 32'h7fff_ffff, PRED,  32'h0},
    '{ROW_CFG,  CFG_MEAS_NOISE, 32'h7fff_ffff, PRED,  32'h0},
    '{ROW_MEAS, NO_REG,         32'h7fff_ffff, PRED,  32'h0},
    '{ROW_MEAS, NO_REG,         32'h8000_0000, PRED,  32'h0},
    '{ROW_MEAS, NO_REG,         32'h0000_0001, PRED,  32'h0},
    // Most negative coefficients A and C with the largest B; the variance can turn negative.
    '{ROW_CFG,  CFG_GAIN_A,     32'h8000_0000, PRED,  32'h0},
    '{ROW_CFG,  CFG_GAIN_B,     32'h7fff_ffff, PRED,  32'h0},
    '{ROW_CFG,  CFG_GAIN_C,     32'h8000_0000, PRED,  32'h0},
    '{ROW_CFG,  CFG_MEAS_NOISE, 32'h0,         PRED,  32'h0},
    '{ROW_MEAS, NO_REG,         32'h4000_0000, PRED,  32'h0},
    '{ROW_MEAS, NO_REG,         32'hc000_0000, PRED,  32'h0},
    // Moderate gains, A and C negative and B positive, with small noise.
    '{ROW_CFG,  CFG_GAIN_A,     32'hffff_0000, PRED,  32'h0},
    '{ROW_CFG,  CFG_GAIN_B,     32'h0000_8000, PRED,  32'h0},
    '{ROW_CFG,  CFG_GAIN_C,     32'hfffe_0000, PRED,  32'h0},
    '{ROW_CFG,  CFG_PROC_NOISE, 32'h0000_0100, PRED,  32'h0},
    '{ROW_CFG,  CFG_MEAS_NOISE, 32'h0000_1000, PRED,  32'h0},
    '{ROW_MEAS, NO_REG,         32'h0005_0000, PRED,  32'h0},
    '{ROW_MEAS, NO_REG,         32'hfffb_0000, PRED,  32'h0},
    '{ROW_MEAS, NO_REG,         32'h0000_0000, PRED,  32'h0},
    // Small measurement coefficient without noise: gain well above one.
    '{ROW_CFG,  CFG_GAIN_A,     32'h0001_0000, PRED,  32'h0},
    '{ROW_CFG,  CFG_GAIN_B,     32'h0,         PRED,  32'h0},
    '{ROW_CFG,  CFG_GAIN_C,     32'h0000_4000, PRED,  32'h0},
    '{ROW_CFG,  CFG_PROC_NOISE, 32'h0,         PRED,  32'h0},
    '{ROW_CFG,  CFG_MEAS_NOISE, 32'h0,         PRED,  32'h0},
    '{ROW_MEAS, NO_REG,         32'h0002_0000, PRED,  32'h0},
    '{ROW_MEAS, NO_REG,         32'hfff0_0000, PRED,  32'h0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [31:0] cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [31:0] measurement
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [31:0] estimate

  scalar_kalman_velocity_filter_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Filter state and register copies, at their reset values.
  longint coef_a = ONE;
  longint coef_b = ONE;
  longint coef_c = ONE;
  longint noise_q = ONE;
  longint noise_r = ONE;
  longint var_init = ONE;
  longint est_now = 0;
  longint est_last = 0;
  longint var_err = 0;
  bit     seen_first = 1'b0;

  logic [31:0] estimates_due[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int          hold_left = 0;
  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;

  function automatic longint sat32(input longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  // Product rounded toward minus infinity, then saturated.
  function automatic longint fx_mul(input longint a, input longint b);
    longint p;
    p = a * b;
    return sat32(p >>> FRAC);
  endfunction

  // Quotient truncated toward zero; a zero divisor gives zero.
  function automatic longint fx_div(input longint n, input longint d);
    if (d == 0) return 0;
    return sat32((n <<< FRAC) / d);
  endfunction

  // One filter step: returns the new estimate and advances the filter state.
  function automatic logic [31:0] next_estimate(input logic [31:0] meas);
    longint m, diff, xpred, ppred, kvar, kgain, innov, xnew, pnew;
    m = longint'($signed(meas));
    if (!seen_first) begin
      var_err = var_init;
      seen_first = 1'b1;
    end
    diff = sat32(est_now - est_last);
    xpred = sat32(fx_mul(coef_a, est_now) + fx_mul(coef_b, diff));
    ppred = sat32(fx_mul(fx_mul(coef_a, var_err), coef_a) + noise_q);
    kvar = sat32(fx_mul(fx_mul(coef_c, ppred), coef_c) + noise_r);
    kgain = (kvar == 0) ? 0 : fx_div(fx_mul(ppred, coef_c), kvar);
    innov = sat32(m - fx_mul(coef_c, xpred));
    xnew = sat32(xpred + fx_mul(kgain, innov));
    pnew = fx_mul(sat32(ONE - fx_mul(kgain, coef_c)), ppred);
    est_last = est_now;
    est_now = xnew;
    var_err = pnew;
    return 32'(xnew);
  endfunction

  // Random register value: extremes, zero, anything, or small (near one for gains A and C).
  function automatic logic [31:0] pick_reg_value(input logic [2:0] idx);
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: v = 32'h7fff_ffff;
      1: v = 32'h8000_0000;
      2: v = 32'h0;
      3, 4: v = $urandom;
      default: begin
        if (idx == CFG_GAIN_B) begin
          v = 32'(int'($urandom_range(0, 32768)) - 16384);
        end else if (idx == CFG_GAIN_A || idx == CFG_GAIN_C) begin
          v = 32'(int'(ONE) + int'($urandom_range(0, 65536)) - 32768);
        end else begin
          // Bit 31 of a noise register is dropped by the block.
          v = {1'($urandom_range(0, 1)), 31'($urandom_range(0, 4 * 65536))};
        end
      end
    endcase
    return v;
  endfunction

  // Random measurement: mostly small signals, sometimes extremes or full range.
  function automatic logic [31:0] pick_measurement();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2, 3: return $urandom;
      default: return 32'(int'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000);
    endcase
  endfunction

  // Register write on the configuration port, mirrored in the filter copy.
  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_GAIN_A:     coef_a = longint'($signed(data));
      CFG_GAIN_B:     coef_b = longint'($signed(data));
      CFG_GAIN_C:     coef_c = longint'($signed(data));
      CFG_PROC_NOISE: noise_q = longint'({1'b0, data[30:0]});
      CFG_MEAS_NOISE: noise_r = longint'({1'b0, data[30:0]});
      CFG_INIT_VAR:   var_init = longint'({1'b0, data[30:0]});
      default: ;
    endcase
  endtask

  // Offer one measurement; on acceptance queue the estimate it must produce.
  task automatic send(input logic [31:0] meas, input logic known, input logic [31:0] typed);
    logic [31:0] predicted;
    @(negedge clk_i);
    if (!tx_steady && $urandom_range(0, 99) < 19) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 90)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = meas;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = next_estimate(meas);
    estimates_due.push_back(known ? typed : predicted);
  endtask

  // Stop offering, let every estimate arrive, then let the block settle.
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (estimates_due.size() != 0) @(posedge clk_i);
    repeat (BUSY_CYCLES) @(posedge clk_i);
  endtask

  // Receiver: random stalls, occasional long ones, and the hold-off for back-pressure.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left == 0 && !rx_steady && $urandom_range(0, 999) < 3) begin
        hold_left = $urandom_range(10, 120);
      end
      if (hold_left > 0) begin
        m_axis_tready = 1'b0;
        hold_left--;
      end else begin
        m_axis_tready = rx_steady || ($urandom_range(0, 99) >= 19);
      end
    end
  end

  // Compare each estimate transaction with the oldest expectation.
  always @(posedge clk_i) begin : check_estimates
    logic [31:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (estimates_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected estimate %h at %0t", m_axis_tdata, $realtime);
        end
      end else begin
        want = estimates_due.pop_front();
        if (m_axis_tdata !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("estimate mismatch at %0t: expected %h, got %h",
                     $realtime, want, m_axis_tdata);
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Main sequence: reset, directed table, random phases, final verdict.
  initial begin
    stim_row_t row;
    bit        items_in_flight;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = NO_REG;
    cfg_data_i = 32'h0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = 32'h0;
    items_in_flight = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table; register writes wait until the block has drained.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row = DIRECTED[i];
      if (row.is_cfg) begin
        if (items_in_flight) begin
          wait_idle();
          items_in_flight = 1'b0;
        end
        cfg_write(row.reg_idx, row.value);
      end else begin
        send(row.value, row.known, row.estimate);
        items_in_flight = 1'b1;
      end
    end

    // Random phases, each under a new register setting.
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      tx_steady = 1'b0;
      rx_steady = 1'b0;
      for (int r = CFG_GAIN_A; r <= CFG_INIT_VAR; r++) begin
        if (ph == 0 || $urandom_range(0, 99) < 60) begin
          cfg_write(3'(r), pick_reg_value(3'(r)));
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        cfg_write($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, $urandom);
      end
      if (ph == STEADY_PHASE) begin
        tx_steady = 1'b1;
        rx_steady = 1'b1;
      end
      if (ph == PRESSURE_PHASE) hold_left = PRESSURE_CYCLES;
      repeat (ITEMS_PER_PHASE) send(pick_measurement(), PRED, 32'h0);
    end

    wait_idle();
    if (mismatches == 0 && estimates_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
